// ----- rtl/bmpp_pkg.sv -----
// ----------------------------------------------------------------------------
// bmpp_pkg
// Shared types and constants for the BMP pixel stream parser.
// ----------------------------------------------------------------------------
package bmpp_pkg;

    // Supported image dimension width; larger headers are rejected.
    localparam int DIM_BITS   = 16;
    localparam int ORIGIN_W   = 16;
    localparam int COORD_W    = 17;
    localparam int SUM_W      = 32;

    // Header layout
    localparam int HDR_SKIP1  = 18;
    localparam int HDR_SKIP2  = 28;
    localparam int HDR_W_LO   = HDR_SKIP1;
    localparam int HDR_H_LO   = HDR_SKIP1 + 4;
    localparam int HDR_H_END  = HDR_SKIP1 + 8;
    localparam int HDR_LAST   = HDR_SKIP1 + 8 + HDR_SKIP2 - 1;
    localparam int HCNT_W     = $clog2(HDR_LAST + 1);
    localparam int DIMW_W     = 32;

    // Stream widths
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 1'd1;

    // Color byte position within a pixel triple
    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PIXEL,
        PH_PAD,
        PH_DONE,
        PH_REJECT
    } t_phase;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               last_pixel;
        logic               rejected;
    } t_pix_res;

endpackage

// ----- rtl/bmpp_core.sv -----
// ----------------------------------------------------------------------------
// bmpp_core
// Parser state: header capture, pixel triple assembly, row and padding
// tracking. Produces at most one result per accepted byte, combinationally.
// ----------------------------------------------------------------------------
module bmpp_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [7:0]                       i_byte,
    input  logic                             i_start,
    input  logic [bmpp_pkg::ORIGIN_W-1:0]    i_origin_x,
    input  logic [bmpp_pkg::ORIGIN_W-1:0]    i_origin_y,
    output logic                             o_res_valid,
    output bmpp_pkg::t_pix_res               o_res
);
    import bmpp_pkg::*;

    t_phase              r_phase, n_phase, cur_phase;
    logic [HCNT_W-1:0]   r_cnt, n_cnt, cur_cnt;
    logic [DIMW_W-1:0]   r_w, n_w, cur_w;
    logic [DIMW_W-1:0]   r_h, n_h, cur_h;
    logic [DIM_BITS-1:0] r_col, n_col;
    logic [DIM_BITS-1:0] r_row, n_row;
    logic [1:0]          r_ch, n_ch;
    logic [1:0]          r_pad, n_pad;
    logic [7:0]          r_blue, n_blue;
    logic [7:0]          r_green, n_green;

    logic [DIM_BITS:0]   col_inc;
    logic                row_end;
    logic                over;
    logic                empty;
    logic                hdr_last;
    logic [1:0]          lane;

    // file_start restarts parsing with this byte as header byte 0
    assign cur_phase = i_start ? PH_HEADER : r_phase;
    assign cur_cnt   = i_start ? '0 : r_cnt;
    assign cur_w     = i_start ? '0 : r_w;
    assign cur_h     = i_start ? '0 : r_h;

    assign col_inc  = {1'b0, r_col} + (DIM_BITS+1)'(1);
    assign row_end  = col_inc >= {1'b0, r_w[DIM_BITS-1:0]};
    assign over     = (r_w[DIMW_W-1:DIM_BITS] != '0) || (r_h[DIMW_W-1:DIM_BITS] != '0);
    assign empty    = (r_w[DIM_BITS-1:0] == '0) || (r_h[DIM_BITS-1:0] == '0);
    assign hdr_last = cur_cnt == HCNT_W'(HDR_LAST);
    assign lane     = 2'(cur_cnt - HCNT_W'(HDR_W_LO));

    // next state
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_w     = r_w;
        n_h     = r_h;
        n_col   = r_col;
        n_row   = r_row;
        n_ch    = r_ch;
        n_pad   = r_pad;
        n_blue  = r_blue;
        n_green = r_green;
        if (i_valid) begin
            n_phase = cur_phase;
            n_cnt   = cur_cnt;
            n_w     = cur_w;
            n_h     = cur_h;
            unique case (cur_phase)
                PH_HEADER: begin
                    if (cur_cnt >= HCNT_W'(HDR_W_LO) && cur_cnt < HCNT_W'(HDR_H_LO)) begin
                        n_w[8*lane +: 8] = i_byte;
                    end else if (cur_cnt >= HCNT_W'(HDR_H_LO)
                                 && cur_cnt < HCNT_W'(HDR_H_END)) begin
                        n_h[8*lane +: 8] = i_byte;
                    end
                    if (!hdr_last) begin
                        n_cnt = cur_cnt + HCNT_W'(1);
                    end else if (over) begin
                        n_phase = PH_REJECT;
                    end else if (empty) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_row   = r_h[DIM_BITS-1:0] - DIM_BITS'(1);
                        n_col   = '0;
                        n_ch    = CH_BLUE;
                        n_phase = PH_PIXEL;
                    end
                end
                PH_PIXEL: begin
                    case (r_ch)
                        CH_BLUE: begin
                            n_blue = i_byte;
                            n_ch   = CH_GREEN;
                        end
                        CH_GREEN: begin
                            n_green = i_byte;
                            n_ch    = CH_RED;
                        end
                        default: begin
                            n_ch = CH_BLUE;
                            if (!row_end) begin
                                n_col = col_inc[DIM_BITS-1:0];
                            end else if (r_row == '0) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_col = '0;
                                n_row = r_row - DIM_BITS'(1);
                                // row padding equals width mod 4
                                n_pad = r_w[1:0];
                                if (r_w[1:0] != 2'd0) begin
                                    n_phase = PH_PAD;
                                end
                            end
                        end
                    endcase
                end
                PH_PAD: begin
                    if (r_pad != 2'd0) begin
                        n_pad = r_pad - 2'd1;
                    end
                    if (r_pad <= 2'd1) begin
                        n_phase = PH_PIXEL;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_valid) begin
            if (cur_phase == PH_HEADER && hdr_last && over) begin
                o_res_valid    = 1'b1;
                o_res.rejected = 1'b1;
            end else if (cur_phase == PH_PIXEL && r_ch != CH_BLUE && r_ch != CH_GREEN) begin
                o_res_valid      = 1'b1;
                o_res.pixel_x    = COORD_W'(SUM_W'(i_origin_x) + SUM_W'(r_col));
                o_res.pixel_y    = COORD_W'(SUM_W'(i_origin_y) + SUM_W'(r_row));
                o_res.red        = i_byte;
                o_res.green      = r_green;
                o_res.blue       = r_blue;
                o_res.last_pixel = row_end && (r_row == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_cnt   <= '0;
            r_w     <= '0;
            r_h     <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_ch    <= CH_BLUE;
            r_pad   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_w     <= n_w;
            r_h     <= n_h;
            r_col   <= n_col;
            r_row   <= n_row;
            r_ch    <= n_ch;
            r_pad   <= n_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blue  <= n_blue;
        r_green <= n_green;
    end

endmodule

// ----- rtl/bmp_pixel_stream_parser.sv -----
// ----------------------------------------------------------------------------
// bmp_pixel_stream_parser
// Parses a 24-bit BMP byte stream into screen points with their color.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle with no gaps required; every byte updates
// only counters and small registers, so the sustained rate is one byte per
// clock while downstream accepts. Each red byte yields a point word the
// cycle after it is accepted, held in an output register. Raise tuser on
// the first byte of each file to restart the parser. Headers 2^16 or more
// wide or tall (top-down negative heights included) give a single word
// with tuser set, then bytes are dropped until the next file start. Write
// origin_x / origin_y only while the stream is idle.
module bmp_pixel_stream_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bmpp_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [7:0] data_byte
    input  logic [0:0]                          s_axis_tuser,  // [0] file_start
    // master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [16:0] pixel_x, [33:17] pixel_y, [41:34] red, [49:42] green,
    // [57:50] blue, [63:58] zero
    output logic [bmpp_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tlast,  // last_pixel
    output logic [0:0]                          m_axis_tuser,  // [0] rejected
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bmpp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bmpp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bmpp_pkg::*;

    logic [ORIGIN_W-1:0] r_origin_x;
    logic [ORIGIN_W-1:0] r_origin_y;
    logic                r_out_valid;
    t_pix_res            r_out;
    logic                in_acc;
    logic                res_valid;
    t_pix_res            res;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    bmpp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_acc),
        .i_byte      (s_axis_tdata[7:0]),
        .i_start     (s_axis_tuser[0]),
        .i_origin_x  (r_origin_x),
        .i_origin_y  (r_origin_y),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X: r_origin_x <= ORIGIN_W'(i_cfg_data);
                CFG_ORIGIN_Y: r_origin_y <= ORIGIN_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // output register: load on every accepted byte, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - 2*COORD_W - 24)'(0), r_out.blue, r_out.green,
                            r_out.red, r_out.pixel_y, r_out.pixel_x};
    assign m_axis_tlast  = r_out.last_pixel;
    assign m_axis_tuser  = r_out.rejected;

endmodule
